// ===== sv/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared constants and types for the two-link leg inverse kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int FRAC_BITS_DEF     = 13;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANG_BITS          = 30;
    localparam int TAB_LEN           = 24;
    localparam int ANG_W             = 36;
    localparam int VEC_W             = 40;
    localparam int SQ_W              = 64;
    localparam int OUT_W             = 18;
    localparam int IN_W              = 16;

    localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    // one vectoring iteration worth of state
    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } cordic_t;

    function automatic ang_t atan_q30(input logic [4:0] i);
        ang_t r;
        r = '0;
        unique case (i)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd11: r = 36'sd524288;
            5'd12: r = 36'sd262144;
            5'd13: r = 36'sd131072;
            5'd14: r = 36'sd65536;
            5'd15: r = 36'sd32768;
            5'd16: r = 36'sd16384;
            5'd17: r = 36'sd8192;
            5'd18: r = 36'sd4096;
            5'd19: r = 36'sd2048;
            5'd20: r = 36'sd1024;
            5'd21: r = 36'sd512;
            5'd22: r = 36'sd256;
            5'd23: r = 36'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/tlik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module tlik_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  tlik_pkg::cordic_t d_in,
    output tlik_pkg::cordic_t d_out
);
    import tlik_pkg::*;

    cordic_t q_reg, q_next;
    vec_t    dx, dy;

    always_comb begin
        dx = d_in.x >>> SHIFT;
        dy = d_in.y >>> SHIFT;
        if (d_in.y > 0) begin
            q_next.x = d_in.x + dy;
            q_next.y = d_in.y - dx;
            q_next.z = d_in.z + atan_q30(5'(SHIFT));
        end else begin
            q_next.x = d_in.x - dy;
            q_next.y = d_in.y + dx;
            q_next.z = d_in.z - atan_q30(5'(SHIFT));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;
endmodule

// ===== sv/tlik_isqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tlik_isqrt_cell
// Two registered restoring square root digit steps for both roots.
// ----------------------------------------------------------------------------
module tlik_isqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [tlik_pkg::SQ_W-1:0] v_in [2],
    input  logic [tlik_pkg::SQ_W-1:0] r_in [2],
    output logic [tlik_pkg::SQ_W-1:0] v_out [2],
    output logic [tlik_pkg::SQ_W-1:0] r_out [2]
);
    import tlik_pkg::*;

    localparam int B0 = 62 - 4 * STEP;
    localparam int B1 = B0 - 2;

    logic [SQ_W-1:0] v_reg [2];
    logic [SQ_W-1:0] r_reg [2];
    logic [SQ_W-1:0] v_next [2];
    logic [SQ_W-1:0] r_next [2];
    logic [SQ_W-1:0] vm [2];
    logic [SQ_W-1:0] rm [2];

    // bit-pair steps in the classic form, starting the bit at 1 << 62
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (v_in[k] >= r_in[k] + (SQ_W'(1) << B0)) begin
                vm[k] = v_in[k] - (r_in[k] + (SQ_W'(1) << B0));
                rm[k] = (r_in[k] >> 1) + (SQ_W'(1) << B0);
            end else begin
                vm[k] = v_in[k];
                rm[k] = r_in[k] >> 1;
            end
            if (vm[k] >= rm[k] + (SQ_W'(1) << B1)) begin
                v_next[k] = vm[k] - (rm[k] + (SQ_W'(1) << B1));
                r_next[k] = (rm[k] >> 1) + (SQ_W'(1) << B1);
            end else begin
                v_next[k] = vm[k];
                r_next[k] = rm[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;
endmodule

// ===== sv/two_link_leg_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics
// Planar two-link leg solver: reach, two square roots, two CORDIC atan2.
// ----------------------------------------------------------------------------
// channel | ports                                   | direction
// s_      | s_valid s_ready s_target_x s_target_y   | foot target in
// m_      | m_valid m_ready m_upper_angle           | angles out
//         | m_lower_angle m_unreachable             |
//
// one transaction per cycle unless the output stalls; pipeline stages, CORDIC capped at 24:
// (1 reach, 16 square root, 1 quadrant fold, CORDIC_STAGES cells, 1 output)
// the whole chain advances only when the output register is free or taken
// synchronous active-low reset clears valid bits only
// ----------------------------------------------------------------------------
module two_link_leg_inverse_kinematics #(
    parameter int FRAC_BITS     = tlik_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [tlik_pkg::IN_W-1:0]  s_target_x,
    input  logic signed [tlik_pkg::IN_W-1:0]  s_target_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [tlik_pkg::OUT_W-1:0] m_upper_angle,
    output logic signed [tlik_pkg::OUT_W-1:0] m_lower_angle,
    output logic                             m_unreachable
);
    import tlik_pkg::*;

    localparam int NST  = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int SQN  = 16;               // square root cells
    localparam int LAT  = 1 + SQN + 1 + NST; // stages before output register
    localparam int UP   = 60 - 2 * FRAC_BITS;
    localparam int SH   = ANG_BITS - FRAC_BITS;
    localparam int FOUR_SH = 2 * FRAC_BITS + 2;

    // pipeline advances as one whole when output can move
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic [LAT:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-1:0], s_valid};
        end
    end

    // stage 0: squared reach, clamp
    logic signed [2*IN_W-1:0] px, py;
    logic [SQ_W-1:0] d2;
    logic [SQ_W-1:0] four;
    logic            unr0;
    logic [SQ_W-1:0] sq_v0_reg [2];
    logic signed [IN_W-1:0] x0_reg, y0_reg;
    logic            unr0_reg;
    always_comb begin
        px   = s_target_x * s_target_x;
        py   = s_target_y * s_target_y;
        four = SQ_W'(1) << FOUR_SH;
        d2   = SQ_W'(px) + SQ_W'(py);
        unr0 = d2 > four;
        if (unr0) begin
            d2 = four;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_v0_reg[0] <= d2 << UP;
            sq_v0_reg[1] <= (four - d2) << UP;
            x0_reg       <= s_target_x;
            y0_reg       <= s_target_y;
            unr0_reg     <= unr0;
        end
    end

    // square root chain, side data travels alongside
    logic [SQ_W-1:0] sv [SQN+1][2];
    logic [SQ_W-1:0] sr [SQN+1][2];
    logic signed [IN_W-1:0] xs_reg [SQN];
    logic signed [IN_W-1:0] ys_reg [SQN];
    logic                   us_reg [SQN];
    assign sv[0] = sq_v0_reg;
    assign sr[0][0] = '0;
    assign sr[0][1] = '0;
    for (genvar g = 0; g < SQN; g++) begin : g_sq
        tlik_isqrt_cell #(.STEP(g)) u_cell (
            .aclk (aclk), .en (adv),
            .v_in (sv[g]), .r_in (sr[g]),
            .v_out(sv[g+1]), .r_out(sr[g+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                xs_reg[g] <= (g == 0) ? x0_reg   : xs_reg[g-1 < 0 ? 0 : g-1];
                ys_reg[g] <= (g == 0) ? y0_reg   : ys_reg[g-1 < 0 ? 0 : g-1];
                us_reg[g] <= (g == 0) ? unr0_reg : us_reg[g-1 < 0 ? 0 : g-1];
            end
        end
    end

    // quadrant fold and preload of both CORDIC chains
    cordic_t ca_in, cb_in;
    logic    za_reg, zb_reg; // origin: atan2 forced to zero
    ang_t    ba_reg, bb_reg;
    logic    uf_reg;
    vec_t    hx, hy;
    always_comb begin
        hx = VEC_W'(xs_reg[SQN-1]) <<< SH;
        hy = VEC_W'(ys_reg[SQN-1]) <<< SH;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            // knee: roots are never negative
            ca_in.x <= VEC_W'(sr[SQN][1]);
            ca_in.y <= VEC_W'(sr[SQN][0]);
            ca_in.z <= '0;
            za_reg  <= (sr[SQN][0] == '0) && (sr[SQN][1] == '0);
            ba_reg  <= '0;
            zb_reg  <= (hx == '0) && (hy == '0);
            if (hx < 0) begin
                cb_in.x <= -hx;
                cb_in.y <= -hy;
                bb_reg  <= (hy >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                cb_in.x <= hx;
                cb_in.y <= hy;
                bb_reg  <= '0;
            end
            cb_in.z <= '0;
            uf_reg  <= us_reg[SQN-1];
        end
    end

    cordic_t ca [NST+1];
    cordic_t cb [NST+1];
    logic    zas_reg [NST], zbs_reg [NST], us2_reg [NST];
    ang_t    bbs_reg [NST];
    assign ca[0] = ca_in;
    assign cb[0] = cb_in;
    for (genvar g = 0; g < NST; g++) begin : g_cor
        tlik_cordic_cell #(.SHIFT(g)) u_ka (
            .aclk(aclk), .en(adv), .d_in(ca[g]), .d_out(ca[g+1]));
        tlik_cordic_cell #(.SHIFT(g)) u_kb (
            .aclk(aclk), .en(adv), .d_in(cb[g]), .d_out(cb[g+1]));
        always_ff @(posedge aclk) begin
            if (adv) begin
                zas_reg[g] <= (g == 0) ? za_reg : zas_reg[g-1 < 0 ? 0 : g-1];
                zbs_reg[g] <= (g == 0) ? zb_reg : zbs_reg[g-1 < 0 ? 0 : g-1];
                bbs_reg[g] <= (g == 0) ? bb_reg : bbs_reg[g-1 < 0 ? 0 : g-1];
                us2_reg[g] <= (g == 0) ? uf_reg : us2_reg[g-1 < 0 ? 0 : g-1];
            end
        end
    end

    // final combine, round and saturate
    ang_t gam, th, alpha, up_a, lo_a;
    logic signed [OUT_W-1:0] up_q, lo_q;

    function automatic logic signed [OUT_W-1:0] to_out(input ang_t a);
        ang_t r;
        r = (a + (ANG_W'(1) <<< (SH - 1))) >>> SH;
        if (r > ang_t'(131071)) begin
            r = ang_t'(131071);
        end else if (r < -ang_t'(131072)) begin
            r = -ang_t'(131072);
        end
        return r[OUT_W-1:0];
    endfunction

    always_comb begin
        gam   = zas_reg[NST-1] ? '0 : (ca[NST].z <<< 1);
        th    = zbs_reg[NST-1] ? '0 : (bbs_reg[NST-1] + cb[NST].z);
        alpha = th - ((PI_Q30 - gam) >>> 1);
        up_a  = PI_Q30 - alpha;
        lo_a  = gam - (PI_Q30 >>> 1);
        up_q  = to_out(up_a);
        lo_q  = to_out(lo_a);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_upper_angle <= up_q;
            m_lower_angle <= lo_q;
            m_unreachable <= us2_reg[NST-1];
        end
    end

    assign m_valid = vld_reg[LAT];
endmodule

// ===== sv/tlik_checker.sv =====
// ----------------------------------------------------------------------------
// tlik_checker
// Port-level checks on the leg solver, bound to the top level.
// ----------------------------------------------------------------------------
module tlik_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic [17:0] m_upper_angle,
    input logic [17:0] m_lower_angle,
    input logic m_unreachable
);
    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_upper_angle)
        && $stable(m_lower_angle) && $stable(m_unreachable))
        else $error("result changed while stalled");

    // input is taken whenever the output is free
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("ready low with empty output");

    // ready follows the output stall
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // reset leaves nothing valid
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind two_link_leg_inverse_kinematics tlik_checker u_tlik_checker (.*);
